### sv/pfsb_pkg.sv
// Shared types, codes and microcode table for the page framebuffer sprite blitter.
// Used by the channel interfaces, the sequencer and the top level; depends on nothing.
package pfsb_pkg;

    // Function codes of a request.
    localparam logic [2:0] FN_PIXEL  = 3'd0;
    localparam logic [2:0] FN_START  = 3'd1;
    localparam logic [2:0] FN_SPRITE = 3'd2;
    localparam logic [2:0] FN_READ   = 3'd3;
    localparam logic [2:0] FN_CLEAR  = 3'd4;

    // Status codes of a result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DROPPED   = 2'd1;
    localparam logic [1:0] ST_IDLE_BYTE = 2'd2;

    // Width of a byte address before the range check against the store size.
    localparam int WADDR_W = 17;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       color;
        logic [7:0] sprite_width;
        logic [7:0] sprite_height;
        logic [7:0] sprite_bits;
        logic [8:0] read_address;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] status;
        logic       sprite_done;
    } out_item_t;

    // Steps of the control program.
    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DISPATCH,
        S_PIX_RD,
        S_PIX_WR,
        S_START,
        S_SPR_CHK,
        S_SPR_RD,
        S_SPR_WR,
        S_RD,
        S_RD_CAP,
        S_CLR,
        S_RESP
    } step_t;

    // Datapath action of one control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_IDLE,
        OP_CLR_WR,
        OP_PIX_RD,
        OP_RMW_PIX,
        OP_START,
        OP_SPR_CHK,
        OP_SPR_RD,
        OP_RMW_SPR,
        OP_RD_ISSUE,
        OP_RD_CAP,
        OP_RESP
    } op_t;

    // Condition that selects between the two successors of a step.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_SWEEP_END,
        C_PIX_BAD,
        C_INACTIVE,
        C_SPR_END,
        C_OUT_FREE,
        C_FUNC
    } csel_t;

    typedef struct packed {
        op_t   op;
        csel_t csel;
        step_t on_true;
        step_t on_false;
    } ctrl_t;

    typedef struct packed {
        logic       accept;
        logic       sweep_end;
        logic       pix_bad;
        logic       inactive;
        logic       spr_end;
        logic       out_free;
        logic [2:0] func;
    } cond_t;

    // The control program: one word per step.
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        unique case (s)
            S_INIT_CLR: w = '{OP_CLR_WR,   C_SWEEP_END, S_IDLE,     S_INIT_CLR};
            S_IDLE:     w = '{OP_IDLE,     C_ACCEPT,    S_DISPATCH, S_IDLE};
            S_DISPATCH: w = '{OP_NONE,     C_FUNC,      S_RESP,     S_RESP};
            S_PIX_RD:   w = '{OP_PIX_RD,   C_PIX_BAD,   S_RESP,     S_PIX_WR};
            S_PIX_WR:   w = '{OP_RMW_PIX,  C_ALWAYS,    S_RESP,     S_RESP};
            S_START:    w = '{OP_START,    C_ALWAYS,    S_RESP,     S_RESP};
            S_SPR_CHK:  w = '{OP_SPR_CHK,  C_INACTIVE,  S_RESP,     S_SPR_RD};
            S_SPR_RD:   w = '{OP_SPR_RD,   C_ALWAYS,    S_SPR_WR,   S_SPR_WR};
            S_SPR_WR:   w = '{OP_RMW_SPR,  C_SPR_END,   S_RESP,     S_SPR_RD};
            S_RD:       w = '{OP_RD_ISSUE, C_ALWAYS,    S_RD_CAP,   S_RD_CAP};
            S_RD_CAP:   w = '{OP_RD_CAP,   C_ALWAYS,    S_RESP,     S_RESP};
            S_CLR:      w = '{OP_CLR_WR,   C_SWEEP_END, S_RESP,     S_CLR};
            S_RESP:     w = '{OP_RESP,     C_OUT_FREE,  S_IDLE,     S_RESP};
            default:    w = '{OP_NONE,     C_ALWAYS,    S_IDLE,     S_IDLE};
        endcase
        return w;
    endfunction

    // First step of the routine for each function code.
    function automatic step_t func_step(input logic [2:0] func);
        step_t s;
        unique case (func)
            FN_PIXEL:  s = S_PIX_RD;
            FN_START:  s = S_START;
            FN_SPRITE: s = S_SPR_CHK;
            FN_READ:   s = S_RD;
            FN_CLEAR:  s = S_CLR;
            default:   s = S_RESP;
        endcase
        return s;
    endfunction

endpackage

### sv/pfsb_in_if.sv
// Request channel of the blitter: valid, ready and one request item.
// Depends on pfsb_pkg for the item type.
interface pfsb_in_if;
    import pfsb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/pfsb_out_if.sv
// Result channel of the blitter: valid, ready and one result item.
// Depends on pfsb_pkg for the item type.
interface pfsb_out_if;
    import pfsb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/pfsb_ram.sv
// Generic single-port RAM with one address, synchronous write and registered read.
// No dependencies.
module pfsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### sv/pfsb_useq.sv
// Microcode sequencer of the blitter: step register, program table and jump selection.
// Depends on pfsb_pkg for the step, control word and condition types.
module pfsb_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  pfsb_pkg::cond_t cond,
    output pfsb_pkg::ctrl_t ctrl
);
    import pfsb_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  taken;

    // Output block: the control word of the current step.
    always_comb
    begin
        ctrl = ucode(step_reg);
    end

    // Next-step block.
    always_comb
    begin
        unique case (ctrl.csel)
            C_ALWAYS:    taken = 1'b1;
            C_ACCEPT:    taken = cond.accept;
            C_SWEEP_END: taken = cond.sweep_end;
            C_PIX_BAD:   taken = cond.pix_bad;
            C_INACTIVE:  taken = cond.inactive;
            C_SPR_END:   taken = cond.spr_end;
            C_OUT_FREE:  taken = cond.out_free;
            C_FUNC:      taken = 1'b1;
            default:     taken = 1'b1;
        endcase
        if (ctrl.csel == C_FUNC)
        begin
            step_next = func_step(cond.func);
        end
        else
        begin
            step_next = taken ? ctrl.on_true : ctrl.on_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_INIT_CLR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### sv/page_framebuffer_sprite_blitter.sv
// Page-layout monochrome framebuffer with pixel drawing, a streamed sprite blitter,
// byte readout and clear. Depends on pfsb_pkg, pfsb_in_if, pfsb_out_if, pfsb_ram, pfsb_useq.
//
// Requests arrive on cmd and each one yields exactly one result on res, in order.
// A byte lives at (y >> 3) * PAGE_STRIDE + x; the pixel is bit y & 7 of it.
// One request is worked on at a time by a microcoded sequencer over a single-port
// store with registered read, so every pixel drawn in the store costs a read and a write step.
// From accepting a request to its result on res the sequencer runs a dispatch step, the
// routine of its code and a response step. Draw pixel reads, then writes (no write when
// the pixel falls outside the store); read byte reads, then captures; a sprite byte reads
// and writes each pixel placed, up to eight; clear writes every byte; start sprite loads
// the walker and other codes add nothing. The next request is taken back in the idle step.
// Results sit in an output register: while res stalls, the block still accepts and
// works on the next request and holds in its response step until the register frees.
// After reset a clearing pass writes zero to all STORE_BYTES bytes, one a cycle;
// cmd.ready stays low until the pass ends. Sprite state resets to idle.
module page_framebuffer_sprite_blitter #(
    parameter int STORE_BYTES = 512,
    parameter int PAGE_STRIDE = 128
) (
    input logic        clk,
    input logic        rst_n,
    pfsb_in_if.sink    cmd,
    pfsb_out_if.source res
);
    import pfsb_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(STORE_BYTES - 1);
    localparam logic [15:0]        STRIDE    = 16'(PAGE_STRIDE);
    localparam logic [WADDR_W-1:0] LIMIT     = WADDR_W'(STORE_BYTES);

    ctrl_t ctrl;
    cond_t cond;

    // Store port.
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_q;

    // Control state.
    logic [AW-1:0] clr_cnt_reg,     clr_cnt_next;
    logic          out_valid_reg,   out_valid_next;
    logic [15:0]   row_base_reg,    row_base_next;
    logic [7:0]    cur_row_reg,     cur_row_next;
    logic [7:0]    cur_col_reg,     cur_col_next;
    logic [7:0]    blit_width_reg,  blit_width_next;
    logic [7:0]    rows_left_reg,   rows_left_next;
    logic          blit_active_reg, blit_active_next;
    logic [2:0]    bit_cnt_reg,     bit_cnt_next;

    // Payload.
    in_item_t      cmd_reg,      cmd_next;
    logic [AW-1:0] addr_reg,     addr_next;
    logic          addr_ok_reg,  addr_ok_next;
    logic          lit_reg,      lit_next;
    logic [2:0]    bitpos_reg,   bitpos_next;
    logic [7:0]    rdata_reg,    rdata_next;
    logic [1:0]    status_reg,   status_next;
    logic          done_reg,     done_next;
    out_item_t     out_data_reg, out_data_next;

    // Datapath values.
    logic [WADDR_W-1:0] pix_addr;
    logic [WADDR_W-1:0] spr_addr;
    logic [WADDR_W-1:0] rd_addr;
    logic [15:0]        start_base;
    logic [7:0]         col_inc;
    logic [7:0]         row_inc;
    logic [7:0]         rows_dec;
    logic               row_end;
    logic               spr_last;
    logic [7:0]         mask;
    logic [7:0]         rmw_data;
    logic               accept;
    logic               out_free;

    pfsb_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    pfsb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    assign cmd.ready = (ctrl.op == OP_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_comb
    begin
        start_base = 16'(cmd_reg.pos_y[7:3]) * STRIDE + 16'(cmd_reg.pos_x);
        pix_addr   = WADDR_W'(start_base);
        spr_addr   = WADDR_W'(row_base_reg) + WADDR_W'(cur_col_reg);
        rd_addr    = WADDR_W'(cmd_reg.read_address);
        col_inc    = cur_col_reg + 8'd1;
        row_inc    = cur_row_reg + 8'd1;
        rows_dec   = rows_left_reg - 8'd1;
        row_end    = (col_inc == blit_width_reg);
        spr_last   = row_end && (rows_dec == 8'd0);
        mask       = 8'd1 << bitpos_reg;
        rmw_data   = lit_reg ? (ram_q | mask) : (ram_q & ~mask);
    end

    always_comb
    begin
        cond.accept    = accept;
        cond.sweep_end = (clr_cnt_reg == LAST_ADDR);
        cond.pix_bad   = (pix_addr >= LIMIT);
        cond.inactive  = !blit_active_reg;
        cond.spr_end   = (bit_cnt_reg == 3'd0) || spr_last;
        cond.out_free  = out_free;
        cond.func      = cmd_reg.func;
    end

    // Store port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr_reg;
        ram_wdata = rmw_data;
        unique case (ctrl.op)
            OP_CLR_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_cnt_reg;
                ram_wdata = 8'd0;
            end
            OP_PIX_RD:   ram_addr = pix_addr[AW-1:0];
            OP_SPR_RD:   ram_addr = spr_addr[AW-1:0];
            OP_RD_ISSUE: ram_addr = rd_addr[AW-1:0];
            OP_RMW_PIX:  ram_we   = addr_ok_reg;
            OP_RMW_SPR:  ram_we   = addr_ok_reg;
            default:     ram_we   = 1'b0;
        endcase
    end

    // Register updates for each step.
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg;
        row_base_next    = row_base_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        blit_width_next  = blit_width_reg;
        rows_left_next   = rows_left_reg;
        blit_active_next = blit_active_reg;
        bit_cnt_next     = bit_cnt_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        addr_ok_next     = addr_ok_reg;
        lit_next         = lit_reg;
        bitpos_next      = bitpos_reg;
        rdata_next       = rdata_reg;
        status_next      = status_reg;
        done_next        = done_reg;
        out_data_next    = out_data_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (ctrl.op)
            OP_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd.data;
                    rdata_next  = 8'd0;
                    status_next = ST_OK;
                    done_next   = 1'b0;
                end
            end
            OP_CLR_WR:
            begin
                clr_cnt_next = (clr_cnt_reg == LAST_ADDR) ? '0 : clr_cnt_reg + AW'(1);
            end
            OP_PIX_RD:
            begin
                addr_next    = pix_addr[AW-1:0];
                addr_ok_next = (pix_addr < LIMIT);
                lit_next     = cmd_reg.color;
                bitpos_next  = cmd_reg.pos_y[2:0];
                if (pix_addr >= LIMIT)
                begin
                    status_next = ST_DROPPED;
                end
            end
            OP_START:
            begin
                row_base_next    = start_base;
                cur_row_next     = cmd_reg.pos_y;
                cur_col_next     = 8'd0;
                blit_width_next  = cmd_reg.sprite_width;
                rows_left_next   = cmd_reg.sprite_height;
                blit_active_next = (cmd_reg.sprite_width != 8'd0)
                                   && (cmd_reg.sprite_height != 8'd0);
            end
            OP_SPR_CHK:
            begin
                bit_cnt_next = 3'd7;
                if (!blit_active_reg)
                begin
                    status_next = ST_IDLE_BYTE;
                end
            end
            OP_SPR_RD:
            begin
                addr_next    = spr_addr[AW-1:0];
                addr_ok_next = (spr_addr < LIMIT);
                lit_next     = cmd_reg.sprite_bits[bit_cnt_reg];
                bitpos_next  = cur_row_reg[2:0];
                if (spr_addr >= LIMIT)
                begin
                    status_next = ST_DROPPED;
                end
            end
            OP_RMW_SPR:
            begin
                // The pixel has been placed; step the sprite on to the next one.
                bit_cnt_next = bit_cnt_reg - 3'd1;
                if (row_end)
                begin
                    cur_col_next   = 8'd0;
                    cur_row_next   = row_inc;
                    rows_left_next = rows_dec;
                    if (row_inc[2:0] == 3'd0)
                    begin
                        row_base_next = row_base_reg + STRIDE;
                    end
                    if (rows_dec == 8'd0)
                    begin
                        blit_active_next = 1'b0;
                        done_next        = 1'b1;
                    end
                end
                else
                begin
                    cur_col_next = col_inc;
                end
            end
            OP_RD_ISSUE:
            begin
                addr_ok_next = (rd_addr < LIMIT);
            end
            OP_RD_CAP:
            begin
                rdata_next = addr_ok_reg ? ram_q : 8'd0;
            end
            OP_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{read_data: rdata_reg, status: status_reg,
                                       sprite_done: done_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            row_base_reg    <= 16'd0;
            cur_row_reg     <= 8'd0;
            cur_col_reg     <= 8'd0;
            blit_width_reg  <= 8'd0;
            rows_left_reg   <= 8'd0;
            blit_active_reg <= 1'b0;
            bit_cnt_reg     <= 3'd0;
        end
        else
        begin
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
            row_base_reg    <= row_base_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            blit_width_reg  <= blit_width_next;
            rows_left_reg   <= rows_left_next;
            blit_active_reg <= blit_active_next;
            bit_cnt_reg     <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        addr_ok_reg  <= addr_ok_next;
        lit_reg      <= lit_next;
        bitpos_reg   <= bitpos_next;
        rdata_reg    <= rdata_next;
        status_reg   <= status_next;
        done_reg     <= done_next;
        out_data_reg <= out_data_next;
    end

    // The store is never written while a request can be taken.
    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !ram_we)
        else $error("store written while idle");

    // An active sprite always has a nonzero width and rows still to draw.
    a_active_dims: assert property (@(posedge clk) disable iff (!rst_n)
        blit_active_reg |-> (blit_width_reg != 8'd0) && (rows_left_reg != 8'd0))
        else $error("active sprite with empty dimensions");

    // A sprite that finishes leaves no active sprite and flags completion.
    a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_RMW_SPR) && spr_last |=> !blit_active_reg && done_reg)
        else $error("sprite end not recorded");

    // A result is only loaded from the response step when the output register is free.
    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |=> $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

### sim/tb_page_framebuffer_sprite_blitter.sv
// Self-checking testbench for page_framebuffer_sprite_blitter: directed and random requests
// are predicted by a behavioural model of the framebuffer and checked result by result.
// Depends on pfsb_pkg, pfsb_in_if, pfsb_out_if and the blitter RTL.
module tb_page_framebuffer_sprite_blitter;
    timeunit 1ns;
    timeprecision 1ps;
    import pfsb_pkg::*;

    localparam int STORE_BYTES = 512;
    localparam int PAGE_STRIDE = 128;
    localparam int ITEM_TARGET = 1050;
    localparam int CALM_ITEMS  = 150;
    localparam int IDLE_LIMIT  = 4000;

    logic clk = 1'b0;
    logic rst_n;

    pfsb_in_if  cmd_if ();
    pfsb_out_if res_if ();

    page_framebuffer_sprite_blitter #(
        .STORE_BYTES(STORE_BYTES),
        .PAGE_STRIDE(PAGE_STRIDE)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_if),
        .res  (res_if)
    );

    always #10 clk = ~clk;

    // Behavioural copy of the framebuffer and the sprite walker.
    logic [7:0]  frame_model [STORE_BYTES];
    logic [15:0] spr_row_base;
    logic [7:0]  spr_row;
    logic [7:0]  spr_col;
    logic [7:0]  spr_width;
    logic [7:0]  spr_rows_left;
    logic        spr_active;

    out_item_t   pending_results [$];
    int          sent_count;
    int          error_count;
    bit          calm;
    int          idle_cycles = 0;
    int          ready_hold = 0;

    function automatic out_item_t blit_predict(input in_item_t req);
        out_item_t   rsp;
        int unsigned addr;
        rsp = '0;
        case (req.func)
            FN_PIXEL:
            begin
                addr = int'(req.pos_x) + int'(req.pos_y >> 3) * PAGE_STRIDE;
                if (addr < STORE_BYTES)
                    frame_model[addr][req.pos_y[2:0]] = req.color;
                else
                    rsp.status = ST_DROPPED;
            end
            FN_START:
            begin
                spr_row_base  = 16'(int'(req.pos_y >> 3) * PAGE_STRIDE + int'(req.pos_x));
                spr_row       = req.pos_y;
                spr_col       = '0;
                spr_width     = req.sprite_width;
                spr_rows_left = req.sprite_height;
                spr_active    = (req.sprite_width != 0) && (req.sprite_height != 0);
            end
            FN_SPRITE:
            begin
                if (!spr_active)
                    rsp.status = ST_IDLE_BYTE;
                else
                begin
                    for (int i = 7; i >= 0; i--)
                    begin
                        if (spr_active)
                        begin
                            addr = int'(spr_row_base) + int'(spr_col);
                            if (addr < STORE_BYTES)
                                frame_model[addr][spr_row[2:0]] = req.sprite_bits[i];
                            else
                                rsp.status = ST_DROPPED;
                            spr_col = spr_col + 8'd1;
                            if (spr_col == spr_width)
                            begin
                                spr_col = '0;
                                spr_row = spr_row + 8'd1;
                                // The row start drops one page each time a page boundary is crossed.
                                if (spr_row[2:0] == 3'd0)
                                    spr_row_base = spr_row_base + 16'(PAGE_STRIDE);
                                spr_rows_left = spr_rows_left - 8'd1;
                                if (spr_rows_left == 0)
                                begin
                                    spr_active      = 1'b0;
                                    rsp.sprite_done = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            FN_READ:
            begin
                if (int'(req.read_address) < STORE_BYTES)
                    rsp.read_data = frame_model[req.read_address];
            end
            FN_CLEAR:
            begin
                foreach (frame_model[k])
                    frame_model[k] = '0;
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    function automatic in_item_t rand_req(input logic [2:0] f);
        in_item_t req;
        req.func          = f;
        req.pos_x         = 8'($urandom);
        req.pos_y         = 8'($urandom);
        req.color         = 1'($urandom);
        req.sprite_width  = 8'($urandom);
        req.sprite_height = 8'($urandom);
        req.sprite_bits   = 8'($urandom);
        req.read_address  = 9'($urandom);
        return req;
    endfunction

    // Sends one request, with an occasional idle burst beforehand, and books its result.
    task automatic send_req(input in_item_t req);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= req;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        pending_results.push_back(blit_predict(req));
        sent_count++;
        if (sent_count >= ITEM_TARGET - CALM_ITEMS)
            calm = 1'b1;
    endtask

    task automatic send_func(input logic [2:0] f);
        send_req(rand_req(f));
    endtask

    task automatic send_pixel(input logic [7:0] x, input logic [7:0] y, input logic c);
        in_item_t req;
        req       = rand_req(FN_PIXEL);
        req.pos_x = x;
        req.pos_y = y;
        req.color = c;
        send_req(req);
    endtask

    task automatic send_start(input logic [7:0] x, input logic [7:0] y,
                              input logic [7:0] w, input logic [7:0] h);
        in_item_t req;
        req               = rand_req(FN_START);
        req.pos_x         = x;
        req.pos_y         = y;
        req.sprite_width  = w;
        req.sprite_height = h;
        send_req(req);
    endtask

    task automatic send_bits(input logic [7:0] b);
        in_item_t req;
        req             = rand_req(FN_SPRITE);
        req.sprite_bits = b;
        send_req(req);
    endtask

    task automatic send_read(input int addr);
        in_item_t req;
        req              = rand_req(FN_READ);
        req.read_address = 9'(addr);
        send_req(req);
    endtask

    task automatic report(input string field, input int exp_val, input int act_val);
        error_count++;
        $display("%0t: %s expected %0h actual %0h", $realtime, field, exp_val, act_val);
    endtask

    // Result checking and randomised back-pressure on the result channel.
    always @(posedge clk)
    begin
        out_item_t exp_rsp;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", 0, int'(res_if.data));
            else
            begin
                exp_rsp = pending_results.pop_front();
                if (res_if.data.read_data !== exp_rsp.read_data)
                    report("read_data", exp_rsp.read_data, res_if.data.read_data);
                if (res_if.data.status !== exp_rsp.status)
                    report("status", exp_rsp.status, res_if.data.status);
                if (res_if.data.sprite_done !== exp_rsp.sprite_done)
                    report("sprite_done", exp_rsp.sprite_done, res_if.data.sprite_done);
            end
        end
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (calm)
            res_if.ready <= 1'b1;
        else if (ready_hold > 0)
        begin
            res_if.ready <= 1'b0;
            ready_hold--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            res_if.ready <= 1'b0;
            ready_hold = $urandom_range(0, 11);
        end
        else
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_pixels();
        send_pixel(8'd0, 8'd0, 1'b1);
        send_pixel(8'd255, 8'd0, 1'b1);
        // Bottom-right byte of the store, then rows past its end.
        send_pixel(8'd127, 8'd31, 1'b1);
        send_pixel(8'd0, 8'd32, 1'b1);
        send_pixel(8'd255, 8'd255, 1'b0);
        send_read(0);
        send_read(255);
        send_read(511);
    endtask

    task automatic test_sprite_control();
        send_bits(8'hA5);
        send_start(8'd20, 8'd0, 8'd0, 8'd5);
        send_bits(8'hFF);
        // A three-pixel sprite: the five bits left over in its byte are ignored.
        send_start(8'd4, 8'd2, 8'd3, 8'd1);
        send_bits(8'hFF);
        send_read(4);
        send_read(7);
    endtask

    task automatic test_sprite_edges();
        // Rows 30 to 33 cross into the page that lies past the end of the store.
        send_start(8'd10, 8'd30, 8'd8, 8'd4);
        send_bits(8'hC3);
        send_func(FN_CLEAR);
        send_bits(8'h3C);
        send_bits(8'hFF);
        send_bits(8'hFF);
        send_read(394);
        send_start(8'd100, 8'd8, 8'd255, 8'd255);
        send_bits(8'h81);
        send_func(3'd5);
        send_func(3'd6);
        send_func(3'd7);
    endtask

    task automatic run_sprite_sequence();
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        int         n_bytes;
        int         base;
        int         kind;
        x    = 8'($urandom);
        y    = 8'($urandom_range(0, 39));
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            w = 8'($urandom_range(200, 255));
            h = 8'($urandom_range(1, 3));
        end
        else if (kind == 1)
        begin
            w = 8'($urandom_range(1, 2));
            h = 8'($urandom_range(200, 255));
        end
        else
        begin
            if (kind < 10)
                x = 8'($urandom_range(0, 127));
            w = 8'($urandom_range(1, 20));
            h = 8'($urandom_range(1, 12));
        end
        n_bytes = (int'(w) * int'(h) + 7) / 8;
        case ($urandom_range(0, 7))
            0: n_bytes = $urandom_range(0, n_bytes);
            1: n_bytes = n_bytes + 1;
            default:
            begin
            end
        endcase
        send_start(x, y, w, h);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_func($urandom_range(0, 1) ? FN_READ : FN_PIXEL);
            send_bits(8'($urandom));
        end
        base = int'(y >> 3) * PAGE_STRIDE + int'(x);
        repeat ($urandom_range(1, 4))
            send_read((base + $urandom_range(0, w)
                       + PAGE_STRIDE * $urandom_range(0, 1)) % STORE_BYTES);
    endtask

    task automatic run_pixel_burst();
        logic [7:0] x;
        logic [7:0] y;
        x = 8'($urandom);
        y = 8'($urandom_range(0, 39));
        repeat ($urandom_range(1, 6))
            send_pixel(x + 8'($urandom_range(0, 3)), y + 8'($urandom_range(0, 9)),
                       1'($urandom));
        repeat ($urandom_range(1, 3))
            send_read((int'(y >> 3) * PAGE_STRIDE + int'(x) + $urandom_range(0, 3)
                       + PAGE_STRIDE * $urandom_range(0, 1)) % STORE_BYTES);
    endtask

    task automatic test_random_traffic();
        int pick;
        while (sent_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                run_sprite_sequence();
            else if (pick < 78)
                run_pixel_burst();
            else if (pick < 97)
                send_func(3'($urandom));
            else
                send_func(FN_CLEAR);
        end
    endtask

    initial
    begin
        foreach (frame_model[k])
            frame_model[k] = '0;
        spr_row_base  = '0;
        spr_row       = '0;
        spr_col       = '0;
        spr_width     = '0;
        spr_rows_left = '0;
        spr_active    = 1'b0;
        sent_count    = 0;
        error_count   = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixels();
        test_sprite_control();
        test_sprite_edges();
        test_random_traffic();

        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (pending_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
sv/pfsb_pkg.sv
sv/pfsb_in_if.sv
sv/pfsb_out_if.sv
sv/pfsb_ram.sv
sv/pfsb_useq.sv
sv/page_framebuffer_sprite_blitter.sv
sim/tb_page_framebuffer_sprite_blitter.sv
